[hw/rtl/asmm_pkg.sv]
package asmm_pkg;

  localparam int CNT_W = 9;
  localparam int COEF_W = 16;
  localparam int FRAC_BITS = 12;
  localparam int CHAN_W = 6;
  localparam int REG_ADDR_W = 4;
  localparam int NUM_IN_W = 5;
  localparam int NUM_OUT_W = 5;
  localparam int NUM_SRC_W = 7;

  localparam logic [1:0] REG_NUM_IN_AMBI = 2'd0;
  localparam logic [1:0] REG_NUM_OUT_AMBI = 2'd1;
  localparam logic [1:0] REG_NUM_SOURCE = 2'd2;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF = 1'b1;

  localparam logic ROUTE_MIXED = 1'b0;
  localparam logic ROUTE_PASS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DUMP,
    ST_PASS
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

[hw/rtl/asmm_cell.sv]
module asmm_cell #(
  parameter int ROW = 0,
  parameter int MAX_AMBI = 16,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COL_W = 4,
  parameter int ACC_W = 37
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  asmm_pkg::cell_ctl_t                 ctl,
  input  logic                                row_act,
  input  logic [3:0]                          wr_row,
  input  logic [COL_W-1:0]                    wr_col,
  input  logic signed [asmm_pkg::COEF_W-1:0]  wr_data,
  input  logic                                tok_in_vld,
  input  logic signed [SAMPLE_WIDTH-1:0]      tok_in_sample,
  input  logic [COL_W-1:0]                    tok_in_col,
  output logic                                tok_out_vld,
  output logic signed [SAMPLE_WIDTH-1:0]      tok_out_sample,
  output logic [COL_W-1:0]                    tok_out_col,
  input  logic signed [ACC_W-1:0]             acc_in,
  output logic signed [ACC_W-1:0]             acc_out
);

  localparam int PROD_W = SAMPLE_WIDTH + asmm_pkg::COEF_W;
  localparam logic [asmm_pkg::CNT_W-1:0] ROW_ID = asmm_pkg::CNT_W'(ROW);

  logic signed [asmm_pkg::COEF_W-1:0] coef_mem [MAX_AMBI];
  logic                               tok_vld_r;
  logic signed [SAMPLE_WIDTH-1:0]     tok_sample_r;
  logic [COL_W-1:0]                   tok_col_r;
  logic                               add_pend_r;
  logic signed [PROD_W-1:0]           prod_r;
  logic signed [ACC_W-1:0]            acc_r;
  logic                               row_hit;

  assign row_hit = (asmm_pkg::CNT_W'(wr_row) == ROW_ID);

  always_ff @(posedge clk) begin
    if (ctl.wr_en && row_hit) begin
      coef_mem[wr_col] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    tok_sample_r <= tok_in_sample;
    tok_col_r <= tok_in_col;
    prod_r <= coef_mem[tok_in_col] * tok_in_sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
      add_pend_r <= 1'b0;
      acc_r <= '0;
    end else begin
      tok_vld_r <= tok_in_vld;
      add_pend_r <= tok_in_vld && row_act;
      if (ctl.clear) begin
        acc_r <= '0;
      end else if (ctl.shift) begin
        acc_r <= acc_in;
      end else if (add_pend_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  assign tok_out_vld = tok_vld_r;
  assign tok_out_sample = tok_sample_r;
  assign tok_out_col = tok_col_r;
  assign acc_out = acc_r;

endmodule

[hw/rtl/ambisonic_split_matrix_mixer_core.sv]
// Split matrix mixer for interleaved audio frames.
// Input channel (in_valid/in_ready): in_cmd selects an audio sample or a
// coefficient write (Q4.12, row/column addressed). Result channel
// (out_valid/out_ready) carries mixed rows (route 0) and passed-through extra
// channels (route 1), with out_last on the final result of a transaction.
// An ambisonic sample travels down a row of MAX_AMBI cells, one cell per
// cycle, each cell holding one output row's coefficients and accumulator.
// On the last ambisonic sample of a frame the accumulators shift out through
// cell 0, one result per cycle while the receiver accepts, with as many
// results as the effective num_out_ambi (clamped to 1..MAX_AMBI). One input
// transaction is worked on at a time.
// Results sit in an output register; while the receiver stalls, the result
// holds and the sequencer waits before producing the next one.
// Reset clears accumulators, frame position and sequencer, and sets all three
// channel-count registers to 4. Coefficients are undefined until written.
// A write to a mapped register through the APB port restarts the frame.
module ambisonic_split_matrix_mixer_core #(
  parameter int MAX_AMBI = 16,
  parameter int MAX_SOURCE_CHANNELS = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_cmd,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_sample,
  input  logic [3:0]                            in_coef_row,
  input  logic [3:0]                            in_coef_col,
  input  logic signed [asmm_pkg::COEF_W-1:0]    in_coef_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_route,
  output logic [asmm_pkg::CHAN_W-1:0]           out_channel,
  output logic signed [SAMPLE_WIDTH-1:0]        out_sample,
  output logic                                  out_clipped,
  output logic                                  out_last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [asmm_pkg::REG_ADDR_W-1:0]       paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int CW = asmm_pkg::CNT_W;
  localparam int COL_W = (MAX_AMBI > 1) ? $clog2(MAX_AMBI) : 1;
  localparam int POS_W = (MAX_SOURCE_CHANNELS > 1) ? $clog2(MAX_SOURCE_CHANNELS) : 1;
  localparam int ACC_W = SAMPLE_WIDTH + asmm_pkg::COEF_W + $clog2(MAX_AMBI) + 1;
  localparam int Q_W = ACC_W - asmm_pkg::FRAC_BITS;
  localparam logic [CW-1:0] MAXA = CW'(MAX_AMBI);
  localparam logic [CW-1:0] MAXS = CW'(MAX_SOURCE_CHANNELS);
  localparam logic [CW-1:0] RUN_LAST = CW'(MAX_AMBI + 2);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic signed [ACC_W-1:0] ROUND_ADD =
    {{(ACC_W - asmm_pkg::FRAC_BITS){1'b0}}, {asmm_pkg::FRAC_BITS{1'b1}}};
  localparam logic signed [Q_W-1:0] SAT_MAX =
    {{(Q_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [Q_W-1:0] SAT_MIN =
    {{(Q_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

  logic [asmm_pkg::NUM_IN_W-1:0]  nin_r;
  logic [asmm_pkg::NUM_OUT_W-1:0] nout_r;
  logic [asmm_pkg::NUM_SRC_W-1:0] nsrc_r;
  logic [CW-1:0] nin9, nout9, nin_e, nout_e, nsrc_e;
  logic [1:0]    reg_idx;
  logic          cfg_we;
  logic          cfg_hit;

  asmm_pkg::state_t st_r, st_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CW-1:0]    cur_pos_r, cur_pos_nxt;
  logic signed [SAMPLE_WIDTH-1:0] smp_r, smp_nxt;
  logic             launch_r, launch_nxt;
  logic [CW-1:0]    pos9, pos_eff, pos_inc;

  logic             out_valid_r, out_valid_nxt;
  logic             out_route_r, out_route_nxt;
  logic [asmm_pkg::CHAN_W-1:0] out_chan_r, out_chan_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;
  logic             out_clip_r, out_clip_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_free;
  logic             load;

  asmm_pkg::cell_ctl_t ctl;
  logic [MAX_AMBI-1:0] row_act;

  logic                           tok_vld [MAX_AMBI+1];
  logic signed [SAMPLE_WIDTH-1:0] tok_smp [MAX_AMBI+1];
  logic [COL_W-1:0]               tok_col [MAX_AMBI+1];
  logic signed [ACC_W-1:0]        acc_lnk [MAX_AMBI+1];

  logic signed [ACC_W-1:0] acc_head, acc_adj;
  logic signed [Q_W-1:0]   acc_q;
  logic signed [SAMPLE_WIDTH-1:0] mix_val;
  logic                    mix_clip;

  // configuration port
  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we = psel && penable && pwrite;
  assign cfg_hit = cfg_we && (reg_idx == asmm_pkg::REG_NUM_IN_AMBI ||
                              reg_idx == asmm_pkg::REG_NUM_OUT_AMBI ||
                              reg_idx == asmm_pkg::REG_NUM_SOURCE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nin_r <= asmm_pkg::NUM_IN_W'(4);
      nout_r <= asmm_pkg::NUM_OUT_W'(4);
      nsrc_r <= asmm_pkg::NUM_SRC_W'(4);
    end else if (cfg_we) begin
      unique case (reg_idx)
        asmm_pkg::REG_NUM_IN_AMBI:  nin_r <= pwdata[asmm_pkg::NUM_IN_W-1:0];
        asmm_pkg::REG_NUM_OUT_AMBI: nout_r <= pwdata[asmm_pkg::NUM_OUT_W-1:0];
        asmm_pkg::REG_NUM_SOURCE:   nsrc_r <= pwdata[asmm_pkg::NUM_SRC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      asmm_pkg::REG_NUM_IN_AMBI:  prdata = 32'(nin_r);
      asmm_pkg::REG_NUM_OUT_AMBI: prdata = 32'(nout_r);
      asmm_pkg::REG_NUM_SOURCE:   prdata = 32'(nsrc_r);
      default:                    prdata = '0;
    endcase
  end

  // effective channel counts
  always_comb begin
    nin9 = CW'(nin_r);
    nout9 = CW'(nout_r);
    nin_e = (nin9 == '0) ? ONE : ((nin9 > MAXA) ? MAXA : nin9);
    nout_e = (nout9 == '0) ? ONE : ((nout9 > MAXA) ? MAXA : nout9);
    nsrc_e = CW'(nsrc_r);
    if (nsrc_e < nin_e) begin
      nsrc_e = nin_e;
    end
    if (nsrc_e > MAXS) begin
      nsrc_e = MAXS;
    end
  end

  assign pos9 = CW'(pos_r);
  assign pos_eff = (pos9 >= nsrc_e) ? '0 : pos9;
  assign pos_inc = ((pos_eff + ONE) >= nsrc_e) ? '0 : (pos_eff + ONE);

  // truncate toward zero and saturate the row leaving cell 0
  assign acc_head = acc_lnk[0];
  assign acc_adj = acc_head + (acc_head[ACC_W-1] ? ROUND_ADD : '0);
  assign acc_q = acc_adj[ACC_W-1:asmm_pkg::FRAC_BITS];

  always_comb begin
    mix_clip = 1'b0;
    mix_val = acc_q[SAMPLE_WIDTH-1:0];
    if (acc_q > SAT_MAX) begin
      mix_clip = 1'b1;
      mix_val = SAT_MAX[SAMPLE_WIDTH-1:0];
    end else if (acc_q < SAT_MIN) begin
      mix_clip = 1'b1;
      mix_val = SAT_MIN[SAMPLE_WIDTH-1:0];
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    cur_pos_nxt = cur_pos_r;
    smp_nxt = smp_r;
    launch_nxt = 1'b0;
    in_ready = 1'b0;
    load = 1'b0;
    ctl = '0;
    out_route_nxt = out_route_r;
    out_chan_nxt = out_chan_r;
    out_sample_nxt = out_sample_r;
    out_clip_nxt = out_clip_r;
    out_last_nxt = out_last_r;

    unique case (st_r)
      asmm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == asmm_pkg::CMD_COEF) begin
            ctl.wr_en = (CW'(in_coef_row) < MAXA) && (CW'(in_coef_col) < MAXA);
          end else begin
            cur_pos_nxt = pos_eff;
            smp_nxt = in_sample;
            pos_nxt = pos_inc[POS_W-1:0];
            cnt_nxt = '0;
            if (pos_eff < nin_e) begin
              launch_nxt = 1'b1;
              st_nxt = asmm_pkg::ST_RUN;
            end else begin
              st_nxt = asmm_pkg::ST_PASS;
            end
          end
        end
      end
      asmm_pkg::ST_RUN: begin
        cnt_nxt = cnt_r + ONE;
        if (cnt_r == RUN_LAST) begin
          cnt_nxt = '0;
          st_nxt = (cur_pos_r == (nin_e - ONE)) ? asmm_pkg::ST_DUMP : asmm_pkg::ST_IDLE;
        end
      end
      asmm_pkg::ST_DUMP: begin
        if (out_free) begin
          load = 1'b1;
          ctl.shift = 1'b1;
          out_route_nxt = asmm_pkg::ROUTE_MIXED;
          out_chan_nxt = cnt_r[asmm_pkg::CHAN_W-1:0];
          out_sample_nxt = mix_val;
          out_clip_nxt = mix_clip;
          out_last_nxt = (cnt_r == (nout_e - ONE));
          cnt_nxt = cnt_r + ONE;
          if (cnt_r == (nout_e - ONE)) begin
            st_nxt = asmm_pkg::ST_IDLE;
          end
        end
      end
      asmm_pkg::ST_PASS: begin
        if (out_free) begin
          load = 1'b1;
          out_route_nxt = asmm_pkg::ROUTE_PASS;
          out_chan_nxt = CW'(cur_pos_r - nin_e) >> 0 == '0 ? '0 :
                         asmm_pkg::CHAN_W'(cur_pos_r - nin_e);
          out_sample_nxt = smp_r;
          out_clip_nxt = 1'b0;
          out_last_nxt = 1'b1;
          st_nxt = asmm_pkg::ST_IDLE;
        end
      end
      default: st_nxt = asmm_pkg::ST_IDLE;
    endcase

    if (cfg_hit) begin
      ctl.clear = 1'b1;
      pos_nxt = '0;
    end

    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= asmm_pkg::ST_IDLE;
      cnt_r <= '0;
      pos_r <= '0;
      launch_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
      launch_r <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_pos_r <= cur_pos_nxt;
    smp_r <= smp_nxt;
    out_route_r <= out_route_nxt;
    out_chan_r <= out_chan_nxt;
    out_sample_r <= out_sample_nxt;
    out_clip_r <= out_clip_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_route = out_route_r;
  assign out_channel = out_chan_r;
  assign out_sample = out_sample_r;
  assign out_clipped = out_clip_r;
  assign out_last = out_last_r;

  // row of cells
  assign tok_vld[0] = launch_r;
  assign tok_smp[0] = smp_r;
  assign tok_col[0] = cur_pos_r[COL_W-1:0];
  assign acc_lnk[MAX_AMBI] = '0;

  for (genvar k = 0; k < MAX_AMBI; k++) begin : g_cell
    assign row_act[k] = (CW'(k) < nout_e);

    asmm_cell #(
      .ROW          (k),
      .MAX_AMBI     (MAX_AMBI),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COL_W        (COL_W),
      .ACC_W        (ACC_W)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctl            (ctl),
      .row_act        (row_act[k]),
      .wr_row         (in_coef_row),
      .wr_col         (COL_W'(CW'(in_coef_col))),
      .wr_data        (in_coef_value),
      .tok_in_vld     (tok_vld[k]),
      .tok_in_sample  (tok_smp[k]),
      .tok_in_col     (tok_col[k]),
      .tok_out_vld    (tok_vld[k+1]),
      .tok_out_sample (tok_smp[k+1]),
      .tok_out_col    (tok_col[k+1]),
      .acc_in         (acc_lnk[k+1]),
      .acc_out        (acc_lnk[k])
    );
  end

endmodule

[tb/ambisonic_split_matrix_mixer_core_tb.sv]
`timescale 1ns / 1ps

module ambisonic_split_matrix_mixer_core_tb;

  localparam int MAX_AMBI = 16;
  localparam int MAX_SRC = 64;
  localparam int SW = 16;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam longint SMAX = (longint'(1) << (SW - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  typedef struct {
    logic route;
    logic [asmm_pkg::CHAN_W-1:0] channel;
    logic signed [SW-1:0] value;
    logic clipped;
    logic last;
  } mix_result_t;

  class mixer_scoreboard;
    logic signed [asmm_pkg::COEF_W-1:0] coef_store[MAX_AMBI][MAX_AMBI];
    logic signed [39:0] row_acc[MAX_AMBI];
    int unsigned frame_pos;
    int unsigned n_in_reg;
    int unsigned n_out_reg;
    int unsigned n_src_reg;
    mix_result_t queued_results[$];
    int errors;

    function new();
      n_in_reg = 4;
      n_out_reg = 4;
      n_src_reg = 4;
      errors = 0;
      foreach (coef_store[r, c]) coef_store[r][c] = '0;
      restart_frame();
    endfunction

    function void restart_frame();
      foreach (row_acc[r]) row_acc[r] = '0;
      frame_pos = 0;
    endfunction

    function int unsigned clamp_count(int unsigned v);
      if (v < 1) return 1;
      if (v > MAX_AMBI) return MAX_AMBI;
      return v;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        asmm_pkg::REG_NUM_IN_AMBI: n_in_reg = value[asmm_pkg::NUM_IN_W-1:0];
        asmm_pkg::REG_NUM_OUT_AMBI: n_out_reg = value[asmm_pkg::NUM_OUT_W-1:0];
        asmm_pkg::REG_NUM_SOURCE: n_src_reg = value[asmm_pkg::NUM_SRC_W-1:0];
        default: return;
      endcase
      restart_frame();
    endfunction

    function void apply_input(logic cmd, logic signed [SW-1:0] smp, logic [3:0] row,
                              logic [3:0] col, logic signed [asmm_pkg::COEF_W-1:0] cval);
      int unsigned n_in;
      int unsigned n_out;
      int unsigned n_src;
      int unsigned pos;
      longint mixed;
      mix_result_t res;
      if (cmd == asmm_pkg::CMD_COEF) begin
        coef_store[row][col] = cval;
        return;
      end
      n_in = clamp_count(n_in_reg);
      n_out = clamp_count(n_out_reg);
      n_src = (n_src_reg < n_in) ? n_in : n_src_reg;
      if (n_src > MAX_SRC) n_src = MAX_SRC;
      if (frame_pos >= n_src) frame_pos = 0;
      pos = frame_pos;
      if (pos < n_in) begin
        for (int r = 0; r < n_out; r++) begin
          row_acc[r] = row_acc[r] + coef_store[r][pos] * smp;
        end
        if (pos == n_in - 1) begin
          for (int r = 0; r < n_out; r++) begin
            mixed = row_acc[r] / 40'sd4096;
            res.route = asmm_pkg::ROUTE_MIXED;
            res.channel = asmm_pkg::CHAN_W'(r);
            res.clipped = 1'b0;
            if (mixed > SMAX) begin
              mixed = SMAX;
              res.clipped = 1'b1;
            end else if (mixed < SMIN) begin
              mixed = SMIN;
              res.clipped = 1'b1;
            end
            res.value = mixed[SW-1:0];
            res.last = (r == n_out - 1);
            queued_results.push_back(res);
          end
          foreach (row_acc[r]) row_acc[r] = '0;
        end
      end else begin
        res.route = asmm_pkg::ROUTE_PASS;
        res.channel = asmm_pkg::CHAN_W'(pos - n_in);
        res.value = smp;
        res.clipped = 1'b0;
        res.last = 1'b1;
        queued_results.push_back(res);
      end
      frame_pos = (pos + 1 >= n_src) ? 0 : pos + 1;
    endfunction

    function void report(string field, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_output(mix_result_t got);
      mix_result_t want;
      if (queued_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual route=%0d channel=%0d sample=%0d",
                 $time, got.route, got.channel, got.value);
        return;
      end
      want = queued_results.pop_front();
      if (got.route !== want.route) report("route", want.route, got.route);
      if (got.channel !== want.channel) report("channel", want.channel, got.channel);
      if (got.value !== want.value) report("sample", want.value, got.value);
      if (got.clipped !== want.clipped) report("clipped", want.clipped, got.clipped);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = asmm_pkg::CMD_SAMPLE;
  logic signed [SW-1:0] in_sample = '0;
  logic [3:0] in_coef_row = '0;
  logic [3:0] in_coef_col = '0;
  logic signed [asmm_pkg::COEF_W-1:0] in_coef_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_route;
  logic [asmm_pkg::CHAN_W-1:0] out_channel;
  logic signed [SW-1:0] out_sample;
  logic out_clipped;
  logic out_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [asmm_pkg::REG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  mixer_scoreboard sb;
  bit quiet = 1'b0;
  int hold_request = 0;
  int unsigned cycle_count = 0;

  ambisonic_split_matrix_mixer_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_sample(in_sample),
    .in_coef_row(in_coef_row),
    .in_coef_col(in_coef_col),
    .in_coef_value(in_coef_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_route(out_route),
    .out_channel(out_channel),
    .out_sample(out_sample),
    .out_clipped(out_clipped),
    .out_last(out_last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[ambisonic_split_matrix_mixer_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    mix_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.route = out_route;
      got.channel = out_channel;
      got.value = out_sample;
      got.clipped = out_clipped;
      got.last = out_last;
      sb.check_output(got);
    end
  end

  // receiver: random stalls, plus one long hold on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
      end
    end
  end

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return -16'sd1;
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic signed [asmm_pkg::COEF_W-1:0] pick_coef();
    int v;
    v = int'($urandom_range(0, 8192)) - 4096;
    if ($urandom_range(0, 3) == 0) return asmm_pkg::COEF_W'($urandom);
    return asmm_pkg::COEF_W'(v);
  endfunction

  task automatic send_item(logic cmd, logic signed [SW-1:0] smp, logic [3:0] row,
                           logic [3:0] col, logic signed [asmm_pkg::COEF_W-1:0] cval);
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_sample <= smp;
    in_coef_row <= row;
    in_coef_col <= col;
    in_coef_value <= cval;
    do @(posedge clk); while (!in_ready);
    sb.apply_input(cmd, smp, row, col, cval);
  endtask

  task automatic send_sample(logic signed [SW-1:0] smp);
    send_item(asmm_pkg::CMD_SAMPLE, smp, 4'($urandom), 4'($urandom),
              asmm_pkg::COEF_W'($urandom));
  endtask

  task automatic send_coef(logic [3:0] row, logic [3:0] col,
                           logic signed [asmm_pkg::COEF_W-1:0] cval);
    send_item(asmm_pkg::CMD_COEF, SW'($urandom), row, col, cval);
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_pause();
    if (!quiet && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 4));
  endtask

  task automatic wait_idle();
    pause_sender(1);
    while (sb.queued_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic directed_checks();
    // default setup: 4 in, 4 out, 4 channels; saturate both ways on column 0
    send_coef(4'd0, 4'd0, 16'sh7fff);
    send_coef(4'd1, 4'd0, 16'sh8000);
    send_coef(4'd2, 4'd0, 16'sh1000);
    send_coef(4'd3, 4'd0, 16'shf000);
    send_sample(16'sh7fff);
    send_sample('0);
    send_sample('0);
    send_sample('0);
    // coefficient update lands mid-frame
    send_sample(16'sh8000);
    send_sample('0);
    send_coef(4'd0, 4'd2, 16'sd1);
    send_sample(-16'sd3);
    send_sample(16'sh7fff);
    // small negative sum truncates toward zero
    send_sample('0);
    send_sample('0);
    send_sample(-16'sd5);
    send_sample('0);
    // unmapped register must not restart the frame
    send_sample(16'sd100);
    send_sample(16'sd200);
    wait_idle();
    reg_write(REG_UNMAPPED, 32'd5);
    send_sample(16'sd300);
    send_sample(16'sd400);
    wait_idle();
    reg_write(asmm_pkg::REG_NUM_IN_AMBI, 32'd2);
    reg_write(asmm_pkg::REG_NUM_OUT_AMBI, 32'd3);
    reg_write(asmm_pkg::REG_NUM_SOURCE, 32'd5);
    send_sample(16'sd1000);
    send_sample(-16'sd1000);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
  endtask

  task automatic run_phase(int unsigned n_in, int unsigned n_out, int unsigned n_src,
                           int unsigned n_items, bit long_hold);
    wait_idle();
    reg_write(asmm_pkg::REG_NUM_SOURCE, n_src);
    reg_write(asmm_pkg::REG_NUM_IN_AMBI, n_in);
    reg_write(asmm_pkg::REG_NUM_OUT_AMBI, n_out);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_coef(4'($urandom), 4'($urandom), pick_coef());
      end else begin
        send_sample(pick_sample());
      end
      if (long_hold && i == 4) hold_request = LONG_HOLD_CYCLES;
      maybe_pause();
    end
  endtask

  initial begin
    int unsigned cfg_in[12];
    int unsigned cfg_out[12];
    int unsigned cfg_src[12];
    int unsigned phase_items[12];
    cfg_in = '{4, 0, 1, 16, 31, 16, 1, 3, 8, 2, 16, 5};
    cfg_out = '{4, 0, 1, 16, 31, 1, 16, 5, 8, 2, 16, 3};
    cfg_src = '{4, 0, 1, 64, 127, 16, 40, 2, 20, 63, 16, 9};
    phase_items = '{8, 6, 12, 20, 20, 16, 8, 6, 8, 6, 20, 8};
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // load every coefficient before any sample reads one
    for (int r = 0; r < MAX_AMBI; r++) begin
      for (int c = 0; c < MAX_AMBI; c++) begin
        send_coef(4'(r), 4'(c), pick_coef());
        maybe_pause();
      end
    end

    directed_checks();

    for (int p = 0; p < 12; p++) begin
      if (p == 9 || p == 10) begin
        cfg_in[p] = $urandom_range(0, 31);
        cfg_out[p] = $urandom_range(0, 31);
        cfg_src[p] = $urandom_range(0, 127);
      end
      if (p == 11) quiet = 1'b1;
      run_phase(cfg_in[p], cfg_out[p], cfg_src[p], phase_items[p], p == 2);
    end

    wait_idle();
    if (sb.errors == 0 && sb.queued_results.size() == 0) begin
      $display("[ambisonic_split_matrix_mixer_core] OK");
    end else begin
      $display("[ambisonic_split_matrix_mixer_core] ERROR");
    end
    $finish;
  end

endmodule
